/* hdl/hill_cipher_encrypt_unit_assert.svh */
// ----------------------------------------------------------------------------
// Hill cipher encrypt unit - assertion macros
// Shared concurrent assertion forms for the unit's modules.
// ----------------------------------------------------------------------------
`ifndef HILL_CIPHER_ENCRYPT_UNIT_ASSERT_SVH
`define HILL_CIPHER_ENCRYPT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hce_pkg.sv */
// ----------------------------------------------------------------------------
// Hill cipher encrypt package
// Types, constants and helpers shared by the encrypt unit's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hce_pkg;

  localparam int DEF_MAX_ORDER = 4;
  localparam int KEY_ROWS      = 4;
  localparam int KROW_W        = $clog2(KEY_ROWS);
  localparam int ENTRY_W       = 5;
  localparam int KEY_ROW_W     = KEY_ROWS * ENTRY_W;
  localparam int ORDER_W       = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int MODULUS       = 26;
  localparam int ACC_W         = 12;  // holds KEY_ROWS * 31 * 31
  localparam int RECIP         = 2521; // ceil(2^16 / 26), exact for sums below 2^12
  localparam int RECIP_SHIFT   = 16;
  localparam int QUOT_W        = 8;
  localparam int RESET_ORDER   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_ORDER = 3'd0,
    CFG_KEY_ROW_0 = 3'd1,
    CFG_KEY_ROW_1 = 3'd2,
    CFG_KEY_ROW_2 = 3'd3,
    CFG_KEY_ROW_3 = 3'd4
  } hce_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_QUOT,
    ST_EMIT
  } hce_state_e;

  typedef struct packed {
    logic [ENTRY_W-1:0] plain_letter;
    logic               message_end;
  } hce_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] cipher_letter;
    logic               block_end;
    logic               message_done;
  } hce_out_t;

  typedef struct packed {
    logic busy;
    logic first;
    logic mac_en;
    logic quot_en;
    logic emit;
    logic last_row;
  } hce_ctrl_t;

  // Largest usable block length: bounded by storage and by the key rows.
  function automatic int order_cap(input int max_order);
    return (max_order < KEY_ROWS) ? max_order : KEY_ROWS;
  endfunction

  // Width of a counter that can hold the largest block length.
  function automatic int cnt_width(input int max_order);
    return $clog2(order_cap(max_order) + 1);
  endfunction

  // Pick entry col out of a packed key row.
  function automatic logic [ENTRY_W-1:0] key_entry(input logic [KEY_ROW_W-1:0] row_word,
                                                   input logic [KROW_W-1:0]    col);
    logic [KEY_ROW_W-1:0] shifted;
    shifted = row_word >> (ENTRY_W * int'(col));
    return shifted[ENTRY_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/hce_mac.sv */
// ----------------------------------------------------------------------------
// Hill cipher shared multiply-accumulate unit
// One key-by-letter product per cycle, then a reciprocal mod-26 reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hce_mac (
  input  wire logic                      clk_i,
  input  wire hce_pkg::hce_ctrl_t        ctrl_i,
  input  wire logic [hce_pkg::ENTRY_W-1:0] key_i,
  input  wire logic [hce_pkg::ENTRY_W-1:0] letter_i,
  output logic      [hce_pkg::ENTRY_W-1:0] rem_o
);
  import hce_pkg::*;

  logic [2*ENTRY_W-1:0]         prod;
  logic [ACC_W-1:0]             acc_q, acc_d;
  logic [QUOT_W-1:0]            quot_q, quot_d;
  logic [ACC_W+ACC_W-1:0]       scaled;
  logic [ACC_W-1:0]             quot_mul;

  assign prod = key_i * letter_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.mac_en) begin
      acc_d = ctrl_i.first ? ACC_W'(prod) : acc_q + ACC_W'(prod);
    end
  end

  // Quotient by reciprocal multiply; exact over the accumulator range.
  assign scaled = ACC_W'(acc_q) * ACC_W'(RECIP);

  always_comb begin
    quot_d = quot_q;
    if (ctrl_i.quot_en) begin
      quot_d = scaled[RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    quot_q <= quot_d;
  end

  assign quot_mul = ACC_W'(quot_q) * ACC_W'(MODULUS);
  assign rem_o    = ENTRY_W'(acc_q - quot_mul);

endmodule

`default_nettype wire

/* hdl/hce_seq.sv */
// ----------------------------------------------------------------------------
// Hill cipher block sequencer
// Walks rows and columns of the key matrix and paces the shared MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hce_seq #(
  parameter int MAX_ORDER = hce_pkg::DEF_MAX_ORDER
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        start_i,
  input  wire logic [hce_pkg::cnt_width(MAX_ORDER)-1:0]    order_i,
  input  wire logic                                        out_free_i,
  output hce_pkg::hce_ctrl_t                               ctrl_o,
  output logic      [hce_pkg::cnt_width(MAX_ORDER)-1:0]    row_o,
  output logic      [hce_pkg::cnt_width(MAX_ORDER)-1:0]    col_o
);
  import hce_pkg::*;

  `include "hill_cipher_encrypt_unit_assert.svh"

  localparam int CNT_W = cnt_width(MAX_ORDER);

  hce_state_e       state_q, state_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic             last_col;
  logic             last_row;

  assign last_col = (col_q == order_i - CNT_W'(1));
  assign last_row = (row_q == order_i - CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (last_col) state_d = ST_QUOT;
      end
      ST_QUOT: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) state_d = last_row ? ST_IDLE : ST_MAC;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Counters
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    case (state_q)
      ST_IDLE: begin
        row_d = '0;
        col_d = '0;
      end
      ST_MAC: begin
        col_d = last_col ? '0 : col_q + CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_free_i && !last_row) row_d = row_q + CNT_W'(1);
      end
      default: begin
        row_d = row_q;
        col_d = col_q;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.busy     = (state_q != ST_IDLE);
    ctrl_o.first    = (col_q == '0);
    ctrl_o.last_row = last_row;
    case (state_q)
      ST_MAC:  ctrl_o.mac_en  = 1'b1;
      ST_QUOT: ctrl_o.quot_en = 1'b1;
      ST_EMIT: ctrl_o.emit    = out_free_i;
      default: ctrl_o.mac_en  = 1'b0;
    endcase
  end

  assign row_o = row_q;
  assign col_o = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  `HCE_ASSERT_IMP(a_mac_in_range, clk_i, rst_ni, state_q == ST_MAC, (col_q < order_i) && (row_q < order_i), "MAC index beyond block order")
  `HCE_ASSERT_NXT(a_last_emit_idles, clk_i, rst_ni, ctrl_o.emit && last_row, state_q == ST_IDLE, "sequencer did not idle after last row")
  `HCE_ASSERT_IMP(a_quot_after_mac, clk_i, rst_ni, state_q == ST_QUOT, $past(state_q) == ST_MAC, "reduction entered without accumulation")

endmodule

`default_nettype wire

/* hdl/hill_cipher_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// Hill cipher encrypt unit
// Collects letters into blocks, pads short final blocks, and emits the
// key-matrix product of each block mod 26, one cipher letter per word.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | in_valid_i / in_stall_o   | plain_letter, message_end
//  out     | output    | out_valid_o / out_stall_i | cipher_letter, block_end,
//          |           |                           | message_done
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A letter that does not close a block is stored and advances the fill count.
//  A closing letter starts n rows, each of a MAC step per key column, a
//  reduce step and an emit step, all run on the single shared MAC.
//  The input stalls while a block is in work; a stalled output register holds
//  the emit step, and the next word may be taken while the last result waits.
//  Reset clears the order to 2, the key rows to zero and the fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hill_cipher_encrypt_unit #(
  parameter int MAX_ORDER = hce_pkg::DEF_MAX_ORDER
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // letter input
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire hce_pkg::hce_in_t                in_word_i,
  // cipher output
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output hce_pkg::hce_out_t                    out_word_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [hce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [hce_pkg::KEY_ROW_W-1:0]   cfg_data_i
);
  import hce_pkg::*;

  `include "hill_cipher_encrypt_unit_assert.svh"

  localparam int ORDER_CAP = order_cap(MAX_ORDER);
  localparam int CNT_W     = cnt_width(MAX_ORDER);
  localparam int IDX_W     = $clog2(MAX_ORDER);

  // Configuration registers
  logic [ORDER_W-1:0]   key_order_q, key_order_d;
  logic [KEY_ROW_W-1:0] key_rows_q [KEY_ROWS];
  logic [KEY_ROW_W-1:0] key_rows_d [KEY_ROWS];

  // Block collection
  logic [ENTRY_W-1:0]   block_store_q [MAX_ORDER];
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [CNT_W-1:0]     close_fill_q;
  logic                 last_q;

  // Output register
  logic                 out_valid_q, out_valid_d;
  hce_out_t             out_word_q;

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 out_free;
  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     base_idx;
  logic [CNT_W-1:0]     fill_next;
  logic                 closes;

  hce_ctrl_t            seq_ctrl;
  logic [CNT_W-1:0]     row;
  logic [CNT_W-1:0]     col;
  logic [ENTRY_W-1:0]   mac_key;
  logic [ENTRY_W-1:0]   mac_letter;
  logic [ENTRY_W-1:0]   mac_rem;

  assign in_stall_o  = seq_ctrl.busy;
  assign cfg_ready_o = !seq_ctrl.busy;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Effective block order: zero acts as one, large values saturate.
  always_comb begin
    if (key_order_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(key_order_q) > ORDER_CAP) begin
      n_eff = CNT_W'(ORDER_CAP);
    end else begin
      n_eff = CNT_W'(key_order_q);
    end
  end

  // Drop a stale partial block, then place the letter.
  assign base_idx  = (fill_q >= n_eff) ? '0 : fill_q;
  assign fill_next = base_idx + CNT_W'(1);
  assign closes    = (fill_next >= n_eff) || in_word_i.message_end;

  // Config decode
  always_comb begin
    key_order_d = key_order_q;
    key_rows_d  = key_rows_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_KEY_ORDER: key_order_d   = cfg_data_i[ORDER_W-1:0];
        CFG_KEY_ROW_0: key_rows_d[0] = cfg_data_i;
        CFG_KEY_ROW_1: key_rows_d[1] = cfg_data_i;
        CFG_KEY_ROW_2: key_rows_d[2] = cfg_data_i;
        CFG_KEY_ROW_3: key_rows_d[3] = cfg_data_i;
        default:       key_order_d   = key_order_q;
      endcase
    end
  end

  // Fill count: clear on order rewrite or block close, advance otherwise.
  always_comb begin
    fill_d = fill_q;
    if (cfg_fire && (cfg_index_i == CFG_KEY_ORDER)) begin
      fill_d = '0;
    end else if (in_fire) begin
      fill_d = closes ? '0 : fill_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_order_q <= ORDER_W'(RESET_ORDER);
      for (int r = 0; r < KEY_ROWS; r++) begin
        key_rows_q[r] <= '0;
      end
      fill_q      <= '0;
    end else begin
      key_order_q <= key_order_d;
      key_rows_q  <= key_rows_d;
      fill_q      <= fill_d;
    end
  end

  // Letter store and block close context: payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      block_store_q[IDX_W'(base_idx)] <= in_word_i.plain_letter;
      if (closes) begin
        close_fill_q <= fill_next;
        last_q       <= in_word_i.message_end;
      end
    end
  end

  hce_seq #(
    .MAX_ORDER (MAX_ORDER)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && closes),
    .order_i    (n_eff),
    .out_free_i (out_free),
    .ctrl_o     (seq_ctrl),
    .row_o      (row),
    .col_o      (col)
  );

  // MAC operands: key entry and either a held letter or the pad letter.
  assign mac_key    = key_entry(key_rows_q[KROW_W'(row)], KROW_W'(col));
  assign mac_letter = (col < close_fill_q) ? block_store_q[IDX_W'(col)]
                                           : ENTRY_W'(col - close_fill_q);

  hce_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (seq_ctrl),
    .key_i    (mac_key),
    .letter_i (mac_letter),
    .rem_o    (mac_rem)
  );

  // Output register: load on emit, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_ctrl.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ctrl.emit) begin
      out_word_q.cipher_letter <= mac_rem;
      out_word_q.block_end     <= seq_ctrl.last_row;
      out_word_q.message_done  <= seq_ctrl.last_row && last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `HCE_ASSERT_IMP(a_fill_below_order, clk_i, rst_ni, !seq_ctrl.busy, fill_q < n_eff, "open block count not below order")
  `HCE_ASSERT_NXT(a_close_starts_block, clk_i, rst_ni, in_fire && closes, seq_ctrl.busy, "closing letter did not start block work")
  `HCE_ASSERT_IMP(a_done_on_block_end, clk_i, rst_ni, out_valid_q, !out_word_q.message_done || out_word_q.block_end, "message end flagged off a block end")

endmodule

`default_nettype wire
